[rtl/itra_pkg.sv]
// Shared types, constants and the digit-to-ASCII function for the radix converter.
package itra_pkg;

	localparam int unsigned RADIX_W = 6;
	localparam int unsigned DIGIT_W = 6;
	localparam int unsigned CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	// register index, taken from paddr[2]
	localparam logic REG_RADIX = 1'b0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_LD   = 5'b01000,
		ST_OUT  = 5'b10000
	} itra_state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} itra_div_sts_t;

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 6'd10)
			c = CHAR_ZERO + {1'b0, d};
		else if (d < 6'd36)
			c = CHAR_LETTER + {1'b0, d};
		else
			c = CHAR_ZERO;
		return c;
	endfunction

endpackage

[rtl/itra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module itra_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/itra_divider.sv]
// Bit-serial restoring divider: value by a small base, one quotient bit per cycle.
module itra_divider #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [VALUE_BITS-1:0]          dividend,
	input  logic [itra_pkg::RADIX_W-1:0]   base,
	output logic [VALUE_BITS-1:0]          quotient,
	output logic [itra_pkg::DIGIT_W-1:0]   remainder,
	output itra_pkg::itra_div_sts_t        sts
);

	localparam int unsigned CNT_W = $clog2(VALUE_BITS);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [VALUE_BITS-1:0]        quo_q;
	logic [itra_pkg::DIGIT_W-1:0] rem_q;
	logic [itra_pkg::RADIX_W-1:0] base_q;

	logic [itra_pkg::DIGIT_W:0]   trial;
	logic [itra_pkg::DIGIT_W:0]   diff;
	logic                         ge;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = trial >= {1'b0, base_q};
	assign diff  = trial - {1'b0, base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			base_q <= base;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[itra_pkg::DIGIT_W-1:0] : trial[itra_pkg::DIGIT_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign sts.done  = done_q;
	assign sts.zero  = (quo_q == '0);

endmodule

[rtl/integer_to_radix_ascii.sv]
// Top level: converts an unsigned integer to upper-case ASCII digits in base 2 to 36.
// One word in gives one output word per digit, most significant digit first, tlast on the
// least significant one; zero gives the single digit '0'. The radix register (reset 10)
// holds the written value, which is saturated to 2..36 when used. Digits come from one
// bit-serial divider; digits are kept in a small RAM and read back through its registered
// port, each output word passing through the read, load and output states. The input is
// not ready while a conversion or its output is in progress.
module integer_to_radix_ascii #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] digit_char, [7] zero
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW   = $clog2(VALUE_BITS);
	localparam int unsigned CW   = $clog2(VALUE_BITS + 1);
	localparam int unsigned WIDE = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	itra_pkg::itra_state_t        state_q;
	logic [itra_pkg::RADIX_W-1:0] radix_q;
	logic [itra_pkg::RADIX_W-1:0] base;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                pos_q;
	logic [itra_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;
	logic                         valid_q;

	logic [WIDE-1:0]              in_wide;
	logic [VALUE_BITS-1:0]        dividend;
	logic [VALUE_BITS-1:0]        div_quo;
	logic [itra_pkg::DIGIT_W-1:0] div_rem;
	itra_pkg::itra_div_sts_t      div_sts;
	logic                         div_start;
	logic                         in_fire;
	logic                         cfg_wr;
	logic                         div_end;
	logic [itra_pkg::DIGIT_W-1:0] rd_digit;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == itra_pkg::REG_RADIX);
	assign prdata = (paddr[2] == itra_pkg::REG_RADIX) ? {26'd0, radix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= itra_pkg::RADIX_RESET;
		else if (cfg_wr)
			radix_q <= pwdata[itra_pkg::RADIX_W-1:0];
	end

	always_comb begin
		if (radix_q < itra_pkg::RADIX_MIN)
			base = itra_pkg::RADIX_MIN;
		else if (radix_q > itra_pkg::RADIX_MAX)
			base = itra_pkg::RADIX_MAX;
		else
			base = radix_q;
	end

	assign s_axis_tready = (state_q == itra_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_wide       = WIDE'(s_axis_tdata);
	assign div_end       = (state_q == itra_pkg::ST_DIV) && div_sts.done &&
	                       (div_sts.zero || (cnt_q == CW'(VALUE_BITS - 1)));
	assign div_start     = in_fire ||
	                       ((state_q == itra_pkg::ST_DIV) && div_sts.done && !div_end);
	assign dividend      = in_fire ? in_wide[VALUE_BITS-1:0] : div_quo;

	itra_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.base     (base),
		.quotient (div_quo),
		.remainder(div_rem),
		.sts      (div_sts)
	);

	itra_ram #(
		.WIDTH(itra_pkg::DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_store (
		.clk  (clk),
		.we   ((state_q == itra_pkg::ST_DIV) && div_sts.done),
		.waddr(cnt_q[AW-1:0]),
		.wdata(div_rem),
		.raddr(pos_q),
		.rdata(rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itra_pkg::ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				itra_pkg::ST_IDLE: begin
					if (in_fire) begin
						cnt_q   <= '0;
						state_q <= itra_pkg::ST_DIV;
					end
				end
				itra_pkg::ST_DIV: begin
					if (div_sts.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (div_end) begin
							pos_q   <= cnt_q[AW-1:0];
							state_q <= itra_pkg::ST_RD;
						end
					end
				end
				itra_pkg::ST_RD: begin
					state_q <= itra_pkg::ST_LD;
				end
				itra_pkg::ST_LD: begin
					valid_q <= 1'b1;
					state_q <= itra_pkg::ST_OUT;
				end
				itra_pkg::ST_OUT: begin
					if (m_axis_tready) begin
						valid_q <= 1'b0;
						if (pos_q == '0) begin
							state_q <= itra_pkg::ST_IDLE;
						end else begin
							pos_q   <= pos_q - 1'b1;
							state_q <= itra_pkg::ST_RD;
						end
					end
				end
				default: begin
					state_q <= itra_pkg::ST_IDLE;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == itra_pkg::ST_LD) begin
			char_q <= itra_pkg::digit_ascii(rd_digit);
			last_q <= (pos_q == '0);
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {1'b0, char_q};
	assign m_axis_tlast  = last_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while an output word is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VALUE_BITS))
		else $error("digit count above store depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itra_pkg::ST_OUT) |-> (CW'(pos_q) < cnt_q))
		else $error("read position beyond stored digits");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("block not idle after final digit");

	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (state_q == itra_pkg::ST_OUT))
		else $error("output valid outside output state");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_radix_ascii: directed table, then random radix phases.
module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int TAIL_CYCLES    = 1200;
	localparam int PHASES         = 8;
	localparam int PHASE_VALUES   = 25;

	typedef struct packed {
		logic [itra_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} digit_word_t;

	typedef struct packed {
		logic        cfg;
		logic [31:0] data;
		logic [255:0] txt;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;    // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [6:0] digit_char, [7] zero
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [itra_pkg::RADIX_W-1:0] radix_cfg = itra_pkg::RADIX_RESET;
	digit_word_t expected_digits[$];
	digit_word_t head_word;
	stim_row_t   rows[$];
	int mismatches = 0;
	int values_sent = 0;
	int words_checked = 0;
	int radix_writes = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	integer_to_radix_ascii dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_radix();
		if (radix_cfg < itra_pkg::RADIX_MIN)
			return itra_pkg::RADIX_MIN;
		if (radix_cfg > itra_pkg::RADIX_MAX)
			return itra_pkg::RADIX_MAX;
		return radix_cfg;
	endfunction

	function automatic logic [itra_pkg::CHAR_W-1:0] ascii_of(
			input logic [itra_pkg::DIGIT_W-1:0] d);
		return (d < 6'd10) ? {1'b0, d} + 7'h30 : {1'b0, d} + 7'h37;
	endfunction

	// remainders collected low digit first, queued high digit first
	task automatic push_digit_chars(input logic [31:0] v);
		int unsigned base;
		logic [31:0] q;
		logic [itra_pkg::DIGIT_W-1:0] digs[32];
		int n;
		base = eff_radix();
		q = v;
		n = 0;
		do begin
			digs[n] = itra_pkg::DIGIT_W'(q % base);
			n++;
			q = q / base;
		end while (q != 0);
		for (int k = n - 1; k >= 0; k--)
			expected_digits.push_back('{ascii_of(digs[k]), k == 0});
	endtask

	task automatic push_typed(input logic [255:0] txt);
		bit started;
		started = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (started || txt[i*8 +: 8] != 8'h00) begin
				started = 1'b1;
				expected_digits.push_back('{txt[i*8 +: itra_pkg::CHAR_W], i == 0});
			end
		end
	endtask

	task automatic drain_digits();
		s_axis_tvalid <= 1'b0;
		while (expected_digits.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_radix(input logic [31:0] v);
		drain_digits();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {itra_pkg::REG_RADIX, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		radix_cfg = v[itra_pkg::RADIX_W-1:0];
		radix_writes++;
	endtask

	task automatic send_value(input logic [31:0] v, input logic [255:0] txt);
		if (!calm && $urandom_range(0, 99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		values_sent++;
		if (txt != '0)
			push_typed(txt);
		else
			push_digit_chars(v);
	endtask

	// random words, all-ones shifts, single bits, small values and powers of the radix
	function automatic logic [31:0] pick_value();
		int unsigned base;
		logic [63:0] p;
		int k;
		base = eff_radix();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 2 * base);
			2: return 32'hFFFF_FFFF >> $urandom_range(0, 31);
			3: return 32'h1 << $urandom_range(0, 31);
			default: begin
				p = 64'd1;
				k = $urandom_range(1, 32);
				while (k > 0 && p * base <= 64'hFFFF_FFFF) begin
					p = p * base;
					k--;
				end
				return 32'(p - $urandom_range(0, 1));
			end
		endcase
	endfunction

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= calm || $urandom_range(0, 99) >= 10;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_digits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
			end else begin
				head_word = expected_digits.pop_front();
				words_checked++;
				if (m_axis_tdata !== {1'b0, head_word.ch} || m_axis_tlast !== head_word.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected tdata %h tlast %b, got tdata %h tlast %b",
							{1'b0, head_word.ch}, head_word.last, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: %0d cycles without a handshake", idle_cycles);
					$display("tb_top: errors");
					$finish;
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		logic [itra_pkg::RADIX_W-1:0] phase_radix[PHASES];

		// after reset radix is 10
		rows.push_back('{1'b0, 32'd0, "0"});
		rows.push_back('{1'b0, 32'hFFFF_FFFF, "4294967295"});
		rows.push_back('{1'b0, 32'd1, "1"});
		rows.push_back('{1'b0, 32'd9, '0});
		rows.push_back('{1'b0, 32'd10, '0});
		rows.push_back('{1'b1, 32'd2, '0});
		rows.push_back('{1'b0, 32'hFFFF_FFFF, "11111111111111111111111111111111"});
		rows.push_back('{1'b0, 32'd0, "0"});
		rows.push_back('{1'b0, 32'h8000_0000, '0});
		rows.push_back('{1'b1, 32'd16, '0});
		rows.push_back('{1'b0, 32'hFFFF_FFFF, "FFFFFFFF"});
		rows.push_back('{1'b0, 32'hDEAD_BEEF, '0});
		rows.push_back('{1'b1, 32'd36, '0});
		rows.push_back('{1'b0, 32'hFFFF_FFFF, "1Z141Z3"});
		rows.push_back('{1'b0, 32'd35, "Z"});
		// out-of-range radix saturates to 2 or 36
		rows.push_back('{1'b1, 32'd0, '0});
		rows.push_back('{1'b0, 32'd5, "101"});
		rows.push_back('{1'b1, 32'd1, '0});
		rows.push_back('{1'b0, 32'd2, "10"});
		rows.push_back('{1'b1, 32'd37, '0});
		rows.push_back('{1'b0, 32'd35, "Z"});
		rows.push_back('{1'b1, 32'hFFFF_FFFF, '0});
		rows.push_back('{1'b0, 32'd36, "10"});
		rows.push_back('{1'b0, 32'h1234_5678, '0});

		phase_radix = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd63, 6'd8, 6'd1, 6'd10};
		phase_radix[2] = $urandom_range(3, 35);
		phase_radix[5] = $urandom_range(3, 35);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			row = rows[r];
			if (row.cfg)
				write_radix(row.data);
			else
				send_value(row.data, row.txt);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_radix({2'($urandom_range(0, 3)), 24'd0, phase_radix[p]});
			calm = (p == 3);
			for (int i = 0; i < PHASE_VALUES; i++) begin
				if (p == 1 && i == 5)
					hold_req = 1'b1;
				if (p == 2 && i == 12)
					drain_digits();
				send_value(pick_value(), '0);
			end
			calm = 1'b0;
		end

		drain_digits();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run: %0d values converted, %0d digit words checked, %0d radix writes",
			values_sent, words_checked, radix_writes);
		$display("run: radix 0..63 incl. saturation, zero and all-ones values, sink hold-off");
		if (mismatches == 0 && expected_digits.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
